### rtl/tws_pkg.sv
package tws_pkg;

   localparam int CFG_BITS = 16;

   typedef enum logic [1:0] {
      OP_REG_WR  = 2'd0,
      OP_REG_RD  = 2'd1,
      OP_FIFO_WR = 2'd2,
      OP_FIFO_RD = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SETUP = 3'd1,
      PH_LOW   = 3'd2,
      PH_HIGH  = 3'd3,
      PH_TAIL  = 3'd4,
      PH_GAP   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      CSR_HALF_PERIOD = 2'd0,
      CSR_FIFO_HOLD   = 2'd1,
      CSR_FIFO_GAP    = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   // One tick of the pin sequencer.
   typedef struct packed {
      logic       start;
      op_type     kind;
      logic [6:0] reg_addr;
      logic [7:0] wr_data;
      logic       sdio_in;
   } tws_item_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] half_period;
      logic [CFG_BITS-1:0] fifo_hold;
      logic [CFG_BITS-1:0] fifo_gap;
   } tws_cfg_type;

   // Pin levels and status after one tick.
   typedef struct packed {
      logic       sck;
      logic       sdio_out;
      logic       sdio_oe;
      logic       csb;
      logic       fcsb;
      logic       busy;
      logic [7:0] rd_data;
      logic       rd_valid;
   } tws_pins_type;

   // A programmed count of zero behaves as one tick.
   function automatic logic [CFG_BITS-1:0] wait_load(input logic [CFG_BITS-1:0] v);
      logic [CFG_BITS-1:0] r;
      r = (v == '0) ? CFG_BITS'(1) : v;
      return r;
   endfunction

endpackage

### rtl/tws_seq.sv
module tws_seq import tws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  tws_item_type item,
   input  tws_cfg_type  cfg,
   output tws_pins_type pins
);

   phase_type           phase_ff, phase_in;
   op_type              op_ff, op_in;
   logic [4:0]          bit_count_ff, bit_count_in;
   logic [CFG_BITS-1:0] wait_ff, wait_in;
   logic [15:0]         shift_ff, shift_in;
   logic [7:0]          read_byte_ff, read_byte_in;
   logic                sck_ff, sck_in;
   logic                sdo_ff, sdo_in;
   logic                oe_ff, oe_in;
   logic                csb_ff, csb_in;
   logic                fcsb_ff, fcsb_in;
   logic                rd_pulse;
   logic                go_low;
   logic                go_done;
   logic                is_fifo;

   assign is_fifo = (op_ff == OP_FIFO_WR) || (op_ff == OP_FIFO_RD);

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      bit_count_in = bit_count_ff;
      wait_in      = wait_ff;
      shift_in     = shift_ff;
      read_byte_in = read_byte_ff;
      sck_in       = sck_ff;
      sdo_in       = sdo_ff;
      oe_in        = oe_ff;
      csb_in       = csb_ff;
      fcsb_in      = fcsb_ff;
      rd_pulse     = 1'b0;
      go_low       = 1'b0;
      go_done      = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (item.start) begin
            op_in    = item.kind;
            sck_in   = 1'b0;
            sdo_in   = 1'b1;
            phase_in = PH_SETUP;
            wait_in  = wait_load(cfg.half_period);
            case (item.kind)
               OP_REG_WR, OP_REG_RD: begin
                  oe_in        = 1'b1;
                  fcsb_in      = 1'b1;
                  csb_in       = 1'b0;
                  bit_count_in = 5'd2;
                  // The address MSB selects read (1) or write (0).
                  if (item.kind == OP_REG_WR) begin
                     shift_in = {1'b0, item.reg_addr, item.wr_data};
                  end else begin
                     shift_in = {1'b1, item.reg_addr, 8'h00};
                  end
               end
               default: begin
                  oe_in        = (item.kind == OP_FIFO_WR);
                  fcsb_in      = 1'b0;
                  csb_in       = 1'b1;
                  bit_count_in = 5'd3;
                  shift_in     = (item.kind == OP_FIFO_WR) ? {item.wr_data, 8'h00} : 16'h0000;
               end
            endcase
         end
      end else if (wait_ff > CFG_BITS'(1)) begin
         wait_in = wait_ff - CFG_BITS'(1);
      end else begin
         case (phase_ff)
            PH_SETUP: begin
               if (bit_count_ff > 5'd1) begin
                  bit_count_in = bit_count_ff - 5'd1;
                  wait_in      = wait_load(cfg.half_period);
               end else begin
                  bit_count_in = 5'd0;
                  go_low       = 1'b1;
               end
            end
            PH_LOW: begin
               phase_in = PH_HIGH;
               sck_in   = 1'b1;
               if ((op_ff == OP_FIFO_RD) || (op_ff == OP_REG_RD && bit_count_ff >= 5'd8)) begin
                  shift_in = {shift_ff[14:0], item.sdio_in};
               end
               wait_in = wait_load(cfg.half_period);
            end
            PH_HIGH: begin
               bit_count_in = bit_count_ff + 5'd1;
               if (bit_count_in >= (is_fifo ? 5'd8 : 5'd16)) begin
                  phase_in = PH_TAIL;
                  sck_in   = 1'b0;
                  if (is_fifo) begin
                     wait_in = wait_load(cfg.fifo_hold);
                  end else begin
                     bit_count_in = 5'd2;
                     wait_in      = wait_load(cfg.half_period);
                  end
               end else begin
                  go_low = 1'b1;
               end
            end
            PH_TAIL: begin
               if (is_fifo) begin
                  fcsb_in  = 1'b1;
                  phase_in = PH_GAP;
                  wait_in  = wait_load(cfg.fifo_gap);
               end else if (bit_count_ff > 5'd1) begin
                  bit_count_in = bit_count_ff - 5'd1;
                  wait_in      = wait_load(cfg.half_period);
               end else begin
                  go_done = 1'b1;
               end
            end
            default: begin
               go_done = 1'b1;
            end
         endcase
      end

      // Start of a bit: sck low, then either drive the next bit or release the pin.
      if (go_low) begin
         phase_in = PH_LOW;
         sck_in   = 1'b0;
         if ((op_in == OP_FIFO_RD) || (op_in == OP_REG_RD && bit_count_in >= 5'd8)) begin
            oe_in = 1'b0;
         end else begin
            sdo_in   = shift_in[15];
            shift_in = {shift_in[14:0], 1'b0};
         end
         wait_in = wait_load(cfg.half_period);
      end

      if (go_done) begin
         oe_in        = 1'b0;
         sdo_in       = 1'b1;
         csb_in       = 1'b1;
         fcsb_in      = 1'b1;
         sck_in       = 1'b0;
         phase_in     = PH_IDLE;
         wait_in      = '0;
         bit_count_in = 5'd0;
         if (op_ff == OP_REG_RD || op_ff == OP_FIFO_RD) begin
            read_byte_in = shift_in[7:0];
            rd_pulse     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         op_ff        <= OP_REG_WR;
         bit_count_ff <= '0;
         wait_ff      <= '0;
         shift_ff     <= '0;
         read_byte_ff <= '0;
         sck_ff       <= 1'b0;
         sdo_ff       <= 1'b1;
         oe_ff        <= 1'b1;
         csb_ff       <= 1'b1;
         fcsb_ff      <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         bit_count_ff <= bit_count_in;
         wait_ff      <= wait_in;
         shift_ff     <= shift_in;
         read_byte_ff <= read_byte_in;
         sck_ff       <= sck_in;
         sdo_ff       <= sdo_in;
         oe_ff        <= oe_in;
         csb_ff       <= csb_in;
         fcsb_ff      <= fcsb_in;
      end
   end

   always_comb begin
      pins.sck      = sck_in;
      pins.sdio_out = sdo_in;
      pins.sdio_oe  = oe_in;
      pins.csb      = csb_in;
      pins.fcsb     = fcsb_in;
      pins.busy     = (phase_in != PH_IDLE);
      pins.rd_data  = read_byte_in;
      pins.rd_valid = rd_pulse;
   end

endmodule

### rtl/three_wire_spi_master.sv
// Pin sequencer for a half-duplex 3-wire SPI master with a register select (csb)
// and a FIFO select (fcsb). Each input transaction is one tick of the sequencer
// and returns exactly one result transaction with the pin levels and status after
// that tick. One transaction is taken per clock cycle when the result side is not
// stalled. A result passes through one input register, then the sequencer
// update into the result register. The tick counts for the sck half period,
// FIFO hold and FIFO gap are written through the csr_ port; the user must write
// them only while no request is in progress, as the block does not enforce it;
// a value of zero acts as one tick.
module three_wire_spi_master import tws_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_req_valid,
   input  logic [1:0]          req_req_type,
   input  logic [6:0]          req_reg_addr,
   input  logic [7:0]          req_wr_data,
   input  logic                req_sdio_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_sck,
   output logic                rsp_sdio_out,
   output logic                rsp_sdio_oe,
   output logic                rsp_csb,
   output logic                rsp_fcsb,
   output logic                rsp_busy_res,
   output logic [7:0]          rsp_rd_data,
   output logic                rsp_rd_valid,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_data
);

   logic         in_valid_ff;
   tws_item_type item_ff;
   logic         out_valid_ff;
   tws_pins_type pins_ff;
   tws_pins_type pins_in;
   tws_cfg_type  cfg_ff;
   logic         out_free;
   logic         step;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff.start    <= req_req_valid;
         item_ff.kind     <= op_type'(req_req_type);
         item_ff.reg_addr <= req_reg_addr;
         item_ff.wr_data  <= req_wr_data;
         item_ff.sdio_in  <= req_sdio_in;
      end
      if (step) begin
         pins_ff <= pins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= CFG_BITS'(8);
         cfg_ff.fifo_hold   <= CFG_BITS'(48);
         cfg_ff.fifo_gap    <= CFG_BITS'(96);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_HALF_PERIOD: cfg_ff.half_period <= csr_data;
            CSR_FIFO_HOLD:   cfg_ff.fifo_hold   <= csr_data;
            CSR_FIFO_GAP:    cfg_ff.fifo_gap    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   tws_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .pins  (pins_in)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_sck      = pins_ff.sck;
   assign rsp_sdio_out = pins_ff.sdio_out;
   assign rsp_sdio_oe  = pins_ff.sdio_oe;
   assign rsp_csb      = pins_ff.csb;
   assign rsp_fcsb     = pins_ff.fcsb;
   assign rsp_busy_res = pins_ff.busy;
   assign rsp_rd_data  = pins_ff.rd_data;
   assign rsp_rd_valid = pins_ff.rd_valid;

endmodule
